// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMI_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SMI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/smi_pkg.sv =====
// ----------------------------------------------------------------------------
// smi_pkg
// Shared constants of the segment against quad intersection pipeline.
// ----------------------------------------------------------------------------
package smi_pkg;

	localparam int COORD_BITS_DEF = 21;
	localparam int FRAC_BITS_DEF  = 10;

	// Degenerate triangle threshold is 2^-EPS_LOG2.
	localparam int EPS_LOG2 = 16;

	localparam int FIELD_W  = 63;
	localparam int S_DATA_W = 384;
	localparam int M_DATA_W = 64;
	localparam int M_USER_W = 2;

endpackage

// ===== rtl/core/smi_tri.sv =====
// ----------------------------------------------------------------------------
// smi_tri
// Four-stage triangle test: edge differences, cross products, dot products,
// then the determinant and barycentric range checks.
// ----------------------------------------------------------------------------
module smi_tri import smi_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [COORD_BITS-1:0]   p0 [3],
	input  logic signed [COORD_BITS-1:0]   p1 [3],
	input  logic signed [COORD_BITS-1:0]   v0 [3],
	input  logic signed [COORD_BITS-1:0]   v1 [3],
	input  logic signed [COORD_BITS-1:0]   v2 [3],
	output logic                           ok,
	output logic        [3*COORD_BITS+5:0] t_mag,
	output logic        [3*COORD_BITS+5:0] a_mag
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW + 1;
	localparam int AW = 3 * DW + 4;
	localparam int TW = AW - 1;
	localparam int SH = (3 * FRAC_BITS > EPS_LOG2) ? 3 * FRAC_BITS - EPS_LOG2 : 0;
	localparam logic signed [AW-1:0] THR = AW'(1) << SH;

	function automatic logic signed [PW-1:0] xp(input logic signed [DW-1:0] a1,
		input logic signed [DW-1:0] b2, input logic signed [DW-1:0] a2,
		input logic signed [DW-1:0] b1);
		logic signed [2*DW-1:0] m1;
		logic signed [2*DW-1:0] m2;
		m1 = a1 * b2;
		m2 = a2 * b1;
		return PW'(m1) - PW'(m2);
	endfunction

	function automatic logic signed [AW-1:0] dp(input logic signed [DW-1:0] x0,
		input logic signed [DW-1:0] x1, input logic signed [DW-1:0] x2,
		input logic signed [PW-1:0] y0, input logic signed [PW-1:0] y1,
		input logic signed [PW-1:0] y2);
		logic signed [DW+PW-1:0] m0;
		logic signed [DW+PW-1:0] m1;
		logic signed [DW+PW-1:0] m2;
		m0 = x0 * y0;
		m1 = x1 * y1;
		m2 = x2 * y2;
		return AW'(m0) + AW'(m1) + AW'(m2);
	endfunction

	logic signed [DW-1:0] d_s2 [3], e1_s2 [3], e2_s2 [3], sv_s2 [3];
	logic signed [DW-1:0] d_s3 [3], e1_s3 [3], e2_s3 [3], sv_s3 [3];
	logic signed [PW-1:0] q_s3 [3], r_s3 [3];
	logic signed [AW-1:0] a_s4, u_s4, v_s4, t_s4;
	logic                 ok_s5;
	logic        [TW-1:0] t_s5, a_s5;

	logic signed [AW-1:0] absa, uf, vf, tf, uv;
	logic                 ok_c;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s2[k]  <= DW'(p1[k]) - DW'(p0[k]);
				e1_s2[k] <= DW'(v1[k]) - DW'(v0[k]);
				e2_s2[k] <= DW'(v2[k]) - DW'(v0[k]);
				sv_s2[k] <= DW'(p0[k]) - DW'(v0[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3  <= d_s2;
			e1_s3 <= e1_s2;
			e2_s3 <= e2_s2;
			sv_s3 <= sv_s2;
			q_s3[0] <= xp(d_s2[1], e2_s2[2], d_s2[2], e2_s2[1]);
			q_s3[1] <= xp(d_s2[2], e2_s2[0], d_s2[0], e2_s2[2]);
			q_s3[2] <= xp(d_s2[0], e2_s2[1], d_s2[1], e2_s2[0]);
			r_s3[0] <= xp(sv_s2[1], e1_s2[2], sv_s2[2], e1_s2[1]);
			r_s3[1] <= xp(sv_s2[2], e1_s2[0], sv_s2[0], e1_s2[2]);
			r_s3[2] <= xp(sv_s2[0], e1_s2[1], sv_s2[1], e1_s2[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4 <= dp(e1_s3[0], e1_s3[1], e1_s3[2], q_s3[0], q_s3[1], q_s3[2]);
			u_s4 <= dp(sv_s3[0], sv_s3[1], sv_s3[2], q_s3[0], q_s3[1], q_s3[2]);
			v_s4 <= dp(d_s3[0], d_s3[1], d_s3[2], r_s3[0], r_s3[1], r_s3[2]);
			t_s4 <= dp(e2_s3[0], e2_s3[1], e2_s3[2], r_s3[0], r_s3[1], r_s3[2]);
		end
	end

	// Fold the sign of the determinant into u, v and t so that all range
	// checks compare against the positive magnitude.
	always_comb begin
		absa = a_s4[AW-1] ? -a_s4 : a_s4;
		uf   = a_s4[AW-1] ? -u_s4 : u_s4;
		vf   = a_s4[AW-1] ? -v_s4 : v_s4;
		tf   = a_s4[AW-1] ? -t_s4 : t_s4;
		uv   = uf + vf;
		ok_c = !(absa < THR) && !uf[AW-1] && !vf[AW-1] && !(absa < uv)
			&& !tf[AW-1] && !(absa < tf);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s5 <= ok_c;
			t_s5  <= tf[TW-1:0];
			a_s5  <= absa[TW-1:0];
		end
	end

	assign ok    = ok_s5;
	assign t_mag = t_s5;
	assign a_mag = a_s5;

endmodule

// ===== rtl/core/smi_point.sv =====
// ----------------------------------------------------------------------------
// smi_point
// Hit point unit: picks the winning triangle, forms d*t in partial products,
// divides by the determinant one quotient bit per stage, then rounds,
// offsets from the segment start and saturates.
// ----------------------------------------------------------------------------
module smi_point import smi_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic                           ok1,
	input  logic                           ok2,
	input  logic        [3*COORD_BITS+5:0] t1,
	input  logic        [3*COORD_BITS+5:0] a1,
	input  logic        [3*COORD_BITS+5:0] t2,
	input  logic        [3*COORD_BITS+5:0] a2,
	input  logic signed [COORD_BITS:0]     d [3],
	input  logic signed [COORD_BITS-1:0]   s0 [3],
	output logic                           hit,
	output logic                           second_half,
	output logic        [3*COORD_BITS-1:0] point
);

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int TW = 3 * CB + 6;
	localparam int CK = (TW + 2) / 3;
	localparam int NW = TW + CB;
	localparam int SW = 3 * CK + CB;
	localparam logic signed [CB+1:0] MAXV = (CB+2)'((2 ** (CB - 1)) - 1);
	localparam logic signed [CB+1:0] MINV = (CB+2)'(-(2 ** (CB - 1)));

	logic        [3*CK-1:0] tpad;
	logic        [TW-1:0]   sel_a;
	logic        [CB-1:0]   mag [3];

	logic        [CK+CB-1:0] pp_s1 [3][3];
	logic        [TW-1:0]    den_s1;
	logic                    neg_s1 [3];
	logic signed [CB-1:0]    sp_s1 [3];
	logic                    hit_s1, sec_s1;

	// Index j holds the division state after j quotient bits.
	logic        [TW-1:0]    rem_s [CB+1][3];
	logic        [CB-1:0]    lo_s  [CB+1][3];
	logic        [CB-1:0]    quo_s [CB+1][3];
	logic        [TW-1:0]    den_s [CB+1];
	logic                    neg_s [CB+1][3];
	logic signed [CB-1:0]    sp_s  [CB+1][3];
	logic                    hit_s [CB+1];
	logic                    sec_s [CB+1];

	logic        [SW-1:0]    nsum [3];
	logic        [3*CB-1:0]  packed_c;
	logic                    hit_out_s, sec_out_s;
	logic        [3*CB-1:0]  point_out_s;

	always_comb begin
		tpad  = (3*CK)'(ok1 ? t1 : t2);
		sel_a = ok1 ? a1 : a2;
		for (int k = 0; k < 3; k++) begin
			mag[k] = d[k][DW-1] ? CB'(-d[k]) : CB'(d[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s1[k][j] <= tpad[j*CK +: CK] * mag[k];
				end
				neg_s1[k] <= d[k][DW-1];
				sp_s1[k]  <= s0[k];
			end
			den_s1 <= sel_a;
			hit_s1 <= ok1 | ok2;
			sec_s1 <= !ok1 && ok2;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nsum[k] = SW'(pp_s1[k][0]) + (SW'(pp_s1[k][1]) << CK)
				+ (SW'(pp_s1[k][2]) << (2 * CK));
		end
	end

	// Since t never exceeds the determinant, the quotient fits in CB bits and
	// the upper part of the product already lies below the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				rem_s[0][k] <= nsum[k][NW-1:CB];
				lo_s[0][k]  <= nsum[k][CB-1:0];
				quo_s[0][k] <= '0;
				neg_s[0][k] <= neg_s1[k];
				sp_s[0][k]  <= sp_s1[k];
			end
			den_s[0] <= den_s1;
			hit_s[0] <= hit_s1;
			sec_s[0] <= sec_s1;
		end
	end

	for (genvar j = 0; j < CB; j++) begin : g_div
		logic [TW:0] x [3];
		logic        ge [3];

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				x[k]  = {rem_s[j][k], lo_s[j][k][CB-1]};
				ge[k] = x[k] >= {1'b0, den_s[j]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					rem_s[j+1][k] <= ge[k] ? TW'(x[k] - {1'b0, den_s[j]}) : TW'(x[k]);
					lo_s[j+1][k]  <= {lo_s[j][k][CB-2:0], 1'b0};
					quo_s[j+1][k] <= {quo_s[j][k][CB-2:0], ge[k]};
					neg_s[j+1][k] <= neg_s[j][k];
					sp_s[j+1][k]  <= sp_s[j][k];
				end
				den_s[j+1] <= den_s[j];
				hit_s[j+1] <= hit_s[j];
				sec_s[j+1] <= sec_s[j];
			end
		end
	end

	// Round the magnitude half away from zero, apply the sign of d and clamp.
	always_comb begin
		logic                 rup;
		logic        [CB:0]   qr;
		logic signed [CB+1:0] qs;
		logic signed [CB+1:0] coord;
		logic signed [CB+1:0] sat;
		packed_c = '0;
		for (int k = 0; k < 3; k++) begin
			rup   = {rem_s[CB][k], 1'b0} >= {1'b0, den_s[CB]};
			qr    = (CB+1)'(quo_s[CB][k]) + (CB+1)'(rup);
			qs    = signed'({1'b0, qr});
			coord = (CB+2)'(sp_s[CB][k]) + (neg_s[CB][k] ? -qs : qs);
			if (coord > MAXV) begin
				sat = MAXV;
			end else if (coord < MINV) begin
				sat = MINV;
			end else begin
				sat = coord;
			end
			packed_c[k*CB +: CB] = sat[CB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_out_s   <= hit_s[CB];
			sec_out_s   <= sec_s[CB];
			point_out_s <= hit_s[CB] ? packed_c : '0;
		end
	end

	assign hit         = hit_out_s;
	assign second_half = sec_out_s;
	assign point       = point_out_s;

endmodule

// ===== rtl/core/segment_quad_intersection.sv =====
// ----------------------------------------------------------------------------
// segment_quad_intersection
// Segment against planar quad intersection, one test per clock while no result is held.
// ----------------------------------------------------------------------------
// Takes one transaction per clock and returns one result per transaction, in
// order. The pipeline holds the unpack stage, four triangle test stages run
// for both triangles side by side, two stages that form the product d*t, the
// hit point divider, which resolves one quotient bit per stage, and the output
// stage that rounds and saturates. The whole pipeline advances whenever the
// output register is empty or being read, so a held result stalls the input
// by the same cycle and no data is lost.
module segment_quad_intersection import smi_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// seg_start[62:0], seg_end[125:63], corner_a[188:126], corner_b[251:189],
	// corner_c[314:252], corner_d[377:315], zero fill
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// hit_point[62:0], zero fill
	output logic [M_DATA_W-1:0] m_tdata,
	// hit[0], second_half[1]
	output logic [M_USER_W-1:0] m_tuser
);

	localparam int DW  = COORD_BITS + 1;
	localparam int TW  = 3 * COORD_BITS + 6;
	localparam int LAT = COORD_BITS + 8;

	logic                         en;
	logic [LAT-1:0]               vld_q;

	logic signed [COORD_BITS-1:0] pts_s1 [6][3];
	logic signed [DW-1:0]         d_s2 [3], d_s3 [3], d_s4 [3], d_s5 [3];
	logic signed [COORD_BITS-1:0] s0_s2 [3], s0_s3 [3], s0_s4 [3], s0_s5 [3];

	logic                         ok1, ok2;
	logic        [TW-1:0]         t1, a1, t2, a2;
	logic                         hit, second_half;
	logic        [3*COORD_BITS-1:0] hit_point;

	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				for (int k = 0; k < 3; k++) begin
					pts_s1[i][k] <= s_tdata[i*FIELD_W + k*COORD_BITS +: COORD_BITS];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s2[k] <= DW'(pts_s1[1][k]) - DW'(pts_s1[0][k]);
			end
			s0_s2 <= pts_s1[0];
			d_s3  <= d_s2;
			s0_s3 <= s0_s2;
			d_s4  <= d_s3;
			s0_s4 <= s0_s3;
			d_s5  <= d_s4;
			s0_s5 <= s0_s4;
		end
	end

	smi_tri #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_tri_first (
		.clk  (clk),
		.en   (en),
		.p0   (pts_s1[0]),
		.p1   (pts_s1[1]),
		.v0   (pts_s1[2]),
		.v1   (pts_s1[3]),
		.v2   (pts_s1[4]),
		.ok   (ok1),
		.t_mag(t1),
		.a_mag(a1)
	);

	smi_tri #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_tri_second (
		.clk  (clk),
		.en   (en),
		.p0   (pts_s1[0]),
		.p1   (pts_s1[1]),
		.v0   (pts_s1[2]),
		.v1   (pts_s1[4]),
		.v2   (pts_s1[5]),
		.ok   (ok2),
		.t_mag(t2),
		.a_mag(a2)
	);

	smi_point #(
		.COORD_BITS(COORD_BITS)
	) u_point (
		.clk        (clk),
		.en         (en),
		.ok1        (ok1),
		.ok2        (ok2),
		.t1         (t1),
		.a1         (a1),
		.t2         (t2),
		.a2         (a2),
		.d          (d_s5),
		.s0         (s0_s5),
		.hit        (hit),
		.second_half(second_half),
		.point      (hit_point)
	);

	assign m_tdata = M_DATA_W'(hit_point);
	assign m_tuser = {second_half, hit};

endmodule

// ===== rtl/core/smi_check.sv =====
// ----------------------------------------------------------------------------
// smi_check
// Port level checks of the intersection pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smi_check import smi_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic [M_USER_W-1:0] m_tuser
);

	// A held result must not change until it is taken.
	`SMI_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// The input is stalled exactly when a result is waiting.
	`SMI_ASSERT_SAME(a_ready, 1'b1, s_tready == (!m_tvalid || m_tready))

	// A miss reports no triangle and a zero point.
	`SMI_ASSERT_SAME(a_miss, m_tvalid && !m_tuser[0], !m_tuser[1] && m_tdata == '0)

	// The fill bit above the packed point stays clear.
	`SMI_ASSERT_SAME(a_fill, m_tvalid, !m_tdata[M_DATA_W-1])

endmodule

bind segment_quad_intersection smi_check u_smi_check (.*);
